[src/max_priority_queue_fifo_ties_defines.svh]
// Assertion macros for the port-level checker of the priority queue.
`ifndef MAX_PRIORITY_QUEUE_FIFO_TIES_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_FIFO_TIES_DEFINES_SVH

// Implication checked at every rising edge, muted while reset is asserted.
`define MPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle form: when ante holds, cons must hold in the next cycle.
`define MPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`MPQ_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

[src/mpq_pkg.sv]
// Shared types and codes for the max-first priority queue.
`timescale 1ns / 1ps
`default_nettype none
package mpq_pkg;

	localparam int DATA_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 5;

	// request codes
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] pri;
		logic signed [DATA_W-1:0] val;
	} mpq_entry_t;

	// operation broadcast to every cell in a cycle
	typedef struct packed {
		logic                     push;
		logic                     pop;
		logic signed [DATA_W-1:0] pri;
		logic signed [DATA_W-1:0] val;
	} mpq_cmd_t;

endpackage
`default_nettype wire

[src/max_priority_queue_fifo_ties.sv]
// Top level of the max-first priority queue with first-in-first-out ties.
//
// Usage:
//  - Command channel: a word (req_type, item_value, item_priority) is taken
//    at a rising edge with start high and busy low. req_type selects push
//    or pop; item_value and item_priority matter only for a push.
//  - Result channel: exactly one result word per command, shown for one
//    cycle with done high, in the cycle right after the command edge.
//    The receiver cannot stall; it must take the word when done is high.
//  - The result word is registered, and a new command may be given every cycle
//    once busy is low: each cell of the chain does one priority compare and
//    one neighbor move per cycle, so the whole queue updates together.
//  - The entries sit in a row of cells kept sorted by priority, highest in
//    cell 0. A push slots in behind every entry of equal or higher priority,
//    so equal priorities leave in push order. A pop takes cell 0 and the
//    rest move up one cell.
//  - A push to a full queue is dropped (status overflow), a pop from an
//    empty queue returns nothing (status underflow); neither changes state.
//  - Reset empties the queue at once; busy is high until the first clock
//    edge after reset is released.
`timescale 1ns / 1ps
`default_nettype none
module max_priority_queue_fifo_ties #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                req_type,
	input  wire logic signed [mpq_pkg::DATA_W-1:0]   item_value,
	input  wire logic signed [mpq_pkg::DATA_W-1:0]   item_priority,
	output logic                                     done,
	output logic                                     out_valid,
	output logic signed [mpq_pkg::DATA_W-1:0]        out_value,
	output logic signed [mpq_pkg::DATA_W-1:0]        out_priority,
	output logic [mpq_pkg::STATUS_W-1:0]             status,
	output logic [mpq_pkg::COUNT_W-1:0]              occupancy_count,
	output logic                                     is_empty
);
	import mpq_pkg::*;

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	mpq_entry_t ent  [QUEUE_DEPTH];
	logic       keep [QUEUE_DEPTH];
	mpq_cmd_t   cmd;

	logic             busy_q;
	logic [OCC_W-1:0] occ_q;
	logic             accept;
	logic             full;
	logic             empty;

	logic                     done_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic signed [DATA_W-1:0] out_priority_q;
	logic [STATUS_W-1:0]      status_q;

	logic [OCC_W+COUNT_W-1:0] occ_ext;

	assign accept = start && !busy_q;
	assign empty  = !ent[0].valid;
	assign full   = ent[QUEUE_DEPTH-1].valid;

	// broadcast to the chain; refused requests become no-ops
	assign cmd.push = accept && (req_type == REQ_PUSH) && !full;
	assign cmd.pop  = accept && (req_type == REQ_POP) && !empty;
	assign cmd.pri  = item_priority;
	assign cmd.val  = item_value;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		mpq_entry_t left_ent;
		mpq_entry_t right_ent;
		logic       left_keep;

		if (i == 0) begin : g_head
			assign left_ent  = '0;
			assign left_keep = 1'b1;   // newcomer lands here if it outranks cell 0
		end else begin : g_mid_l
			assign left_ent  = ent[i-1];
			assign left_keep = keep[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_ent = '0;     // last cell empties on pop
		end else begin : g_mid_r
			assign right_ent = ent[i+1];
		end

		mpq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_ent  (left_ent),
			.left_keep (left_keep),
			.right_ent (right_ent),
			.ent       (ent[i]),
			.keep      (keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			occ_q  <= '0;
			done_q <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			done_q <= accept;
			if (cmd.push) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (cmd.pop) begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

	// result word, valid in the cycle after the command
	always_ff @(posedge clk) begin
		if (accept) begin
			out_valid_q    <= cmd.pop;
			out_value_q    <= cmd.pop ? ent[0].val : '0;
			out_priority_q <= cmd.pop ? ent[0].pri : '0;
			priority if (req_type == REQ_PUSH && full) begin
				status_q <= ST_OVERFLOW;
			end else if (req_type == REQ_POP && empty) begin
				status_q <= ST_UNDERFLOW;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	// count is reported modulo 32
	assign occ_ext = {{COUNT_W{1'b0}}, occ_q};

	assign busy            = busy_q;
	assign done            = done_q;
	assign out_valid       = out_valid_q;
	assign out_value       = out_value_q;
	assign out_priority    = out_priority_q;
	assign status          = status_q;
	assign occupancy_count = occ_ext[COUNT_W-1:0];
	assign is_empty        = (occ_q == '0);

endmodule
`default_nettype wire

[src/mpq_cell.sv]
// One slot of the sorted cell chain: holds an entry, shifts on push or pop.
`timescale 1ns / 1ps
`default_nettype none
module mpq_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mpq_pkg::mpq_cmd_t      cmd,
	input  wire mpq_pkg::mpq_entry_t    left_ent,
	input  wire logic                   left_keep,
	input  wire mpq_pkg::mpq_entry_t    right_ent,
	output mpq_pkg::mpq_entry_t         ent,
	output logic                        keep
);
	import mpq_pkg::*;

	logic                     valid_q;
	logic signed [DATA_W-1:0] pri_q;
	logic signed [DATA_W-1:0] val_q;

	// entry stays put on a push when it ranks at or above the newcomer
	assign keep = valid_q && (pri_q >= cmd.pri);
	assign ent  = '{valid: valid_q, pri: pri_q, val: val_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= right_ent.valid;
		end else if (cmd.push && !keep) begin
			valid_q <= left_keep ? 1'b1 : left_ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			pri_q <= right_ent.pri;
			val_q <= right_ent.val;
		end else if (cmd.push && !keep) begin
			if (left_keep) begin
				pri_q <= cmd.pri;
				val_q <= cmd.val;
			end else begin
				pri_q <= left_ent.pri;
				val_q <= left_ent.val;
			end
		end
	end

endmodule
`default_nettype wire

[src/mpq_checker.sv]
// Port-level checks on the priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "max_priority_queue_fifo_ties_defines.svh"
module mpq_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic                          out_valid,
	input wire logic [mpq_pkg::STATUS_W-1:0]  status,
	input wire logic [mpq_pkg::COUNT_W-1:0]   occupancy_count,
	input wire logic                          is_empty
);
	import mpq_pkg::*;

	// every accepted command yields a result word next cycle, and only then
	`MPQ_ASSERT_NEXT(a_done_follows, clk, arst_n, start && !busy, done, "missing result word")
	`MPQ_ASSERT_NEXT(a_no_stray_done, clk, arst_n, !(start && !busy), !done, "stray result word")
	// a returned entry always carries ok status
	`MPQ_ASSERT(a_valid_ok, clk, arst_n, done && out_valid |-> status == ST_OK, "bad pop status")
	// underflow leaves the queue empty with zero count
	`MPQ_ASSERT(a_underflow_empty, clk, arst_n, done && status == ST_UNDERFLOW |-> is_empty && occupancy_count == '0, "underflow on nonempty queue")

endmodule

bind max_priority_queue_fifo_ties mpq_checker u_mpq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.out_valid       (out_valid),
	.status          (status),
	.occupancy_count (occupancy_count),
	.is_empty        (is_empty)
);
`default_nettype wire

[bench/mpq_result_checker.sv]
// Result checker for the max-first priority queue: predicts each result word and compares.
`timescale 1ns / 1ps
`default_nettype none
module mpq_result_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic                              busy,
	input  wire logic                              req_type,
	input  wire logic signed [mpq_pkg::DATA_W-1:0] item_value,
	input  wire logic signed [mpq_pkg::DATA_W-1:0] item_priority,
	input  wire logic                              done,
	input  wire logic                              out_valid,
	input  wire logic signed [mpq_pkg::DATA_W-1:0] out_value,
	input  wire logic signed [mpq_pkg::DATA_W-1:0] out_priority,
	input  wire logic [mpq_pkg::STATUS_W-1:0]      status,
	input  wire logic [mpq_pkg::COUNT_W-1:0]       occupancy_count,
	input  wire logic                              is_empty,
	output int                                     fail_total,
	output int                                     outstanding,
	output int                                     push_cnt,
	output int                                     pop_cnt,
	output int                                     overflow_cnt,
	output int                                     underflow_cnt
);
	import mpq_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic signed [DATA_W-1:0] pri;
	} held_entry_t;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] val;
		logic signed [DATA_W-1:0] pri;
		logic [STATUS_W-1:0]      st;
		logic [COUNT_W-1:0]       count;
		logic                     empty;
	} result_word_t;

	// held entries kept in push order; ties resolve to the lowest index
	held_entry_t  held_entries[$];
	result_word_t awaited_words[$];
	result_word_t want;
	int           failures = 0;

	// Applies one command to the queue copy, returns the word it should produce.
	function automatic result_word_t serve_request(logic req, logic signed [DATA_W-1:0] v,
			logic signed [DATA_W-1:0] p);
		result_word_t r;
		int           best;
		r = '0;
		r.st = ST_OK;
		if (req == REQ_PUSH) begin
			if (held_entries.size() >= QUEUE_DEPTH)
				r.st = ST_OVERFLOW;
			else
				held_entries.push_back('{val: v, pri: p});
		end else if (held_entries.size() == 0) begin
			r.st = ST_UNDERFLOW;
		end else begin
			best = 0;
			// strict compare keeps the oldest of equal priorities
			for (int i = 1; i < held_entries.size(); i++)
				if (held_entries[i].pri > held_entries[best].pri)
					best = i;
			r.valid = 1'b1;
			r.val = held_entries[best].val;
			r.pri = held_entries[best].pri;
			held_entries.delete(best);
		end
		r.count = COUNT_W'(held_entries.size());
		r.empty = (held_entries.size() == 0);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] exp);
		failures++;
		if (failures <= 20)
			$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_entries.delete();
			awaited_words.delete();
			outstanding <= 0;
			fail_total <= 0;
			push_cnt <= 0;
			pop_cnt <= 0;
			overflow_cnt <= 0;
			underflow_cnt <= 0;
		end else begin
			// check first: the word due now belongs to an earlier command
			if (done) begin
				if (awaited_words.size() == 0) begin
					report_mismatch("word with none outstanding", 0, 0);
				end else begin
					want = awaited_words.pop_front();
					if (out_valid !== want.valid)
						report_mismatch("out_valid", out_valid, want.valid);
					if (out_value !== want.val)
						report_mismatch("out_value", out_value, want.val);
					if (out_priority !== want.pri)
						report_mismatch("out_priority", out_priority, want.pri);
					if (status !== want.st)
						report_mismatch("status", status, want.st);
					if (occupancy_count !== want.count)
						report_mismatch("occupancy_count", occupancy_count, want.count);
					if (is_empty !== want.empty)
						report_mismatch("is_empty", is_empty, want.empty);
				end
			end
			if (start && !busy) begin
				want = serve_request(req_type, item_value, item_priority);
				awaited_words.push_back(want);
				if (req_type == REQ_PUSH)
					push_cnt <= push_cnt + 1;
				else
					pop_cnt <= pop_cnt + 1;
				if (want.st == ST_OVERFLOW)
					overflow_cnt <= overflow_cnt + 1;
				if (want.st == ST_UNDERFLOW)
					underflow_cnt <= underflow_cnt + 1;
			end
			outstanding <= awaited_words.size();
			fail_total <= failures;
		end
	end

endmodule
`default_nettype wire

[bench/tb.sv]
// Top of the priority queue bench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import mpq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 660;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     req_type = REQ_PUSH;
	logic signed [DATA_W-1:0] item_value = '0;
	logic signed [DATA_W-1:0] item_priority = '0;
	logic                     busy;
	logic                     done;
	logic                     out_valid;
	logic signed [DATA_W-1:0] out_value;
	logic signed [DATA_W-1:0] out_priority;
	logic [STATUS_W-1:0]      status;
	logic [COUNT_W-1:0]       occupancy_count;
	logic                     is_empty;

	int fail_total, outstanding;
	int push_cnt, pop_cnt, overflow_cnt, underflow_cnt;
	int cycles = 0;

	always #4 clk = ~clk;

	max_priority_queue_fifo_ties #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk, .arst_n, .start, .busy, .req_type, .item_value, .item_priority,
		.done, .out_valid, .out_value, .out_priority, .status, .occupancy_count, .is_empty
	);

	mpq_result_checker #(.QUEUE_DEPTH(DEPTH)) u_result_chk (
		.clk, .arst_n, .start, .busy, .req_type, .item_value, .item_priority,
		.done, .out_valid, .out_value, .out_priority, .status, .occupancy_count, .is_empty,
		.fail_total, .outstanding, .push_cnt, .pop_cnt, .overflow_cnt, .underflow_cnt
	);

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Presents one command word and holds it until the edge that takes it.
	// start stays high afterwards; only an idle gap or the end of stimulus lowers it.
	task automatic send_word(logic req, logic signed [DATA_W-1:0] v,
			logic signed [DATA_W-1:0] p);
		start <= 1'b1;
		req_type <= req;
		item_value <= v;
		item_priority <= p;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Sender gaps: each cycle idles with the given odds, so gaps are geometric.
	task automatic sender_gap(int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Priorities crowd a few values so ties are common, with extremes mixed in.
	function automatic logic signed [DATA_W-1:0] pick_priority();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: pick_priority = $signed($urandom_range(3)) - 1;
			6:                pick_priority = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			7, 8:             pick_priority = $urandom;
			default:          pick_priority = $urandom_range(15);
		endcase
	endfunction

	initial begin
		int idle_pct, run_left, push_odds, no_idle_left;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: pop on empty, extreme values and priorities, ties
		send_word(REQ_POP, 32'sh12345678, 32'sh7fffffff);
		send_word(REQ_PUSH, 32'sh7fffffff, 32'sh80000000);
		send_word(REQ_PUSH, 32'sh80000000, 32'sh7fffffff);
		send_word(REQ_PUSH, 32'sd1, 32'sh7fffffff);
		send_word(REQ_PUSH, -32'sd1, -32'sd1);
		send_word(REQ_PUSH, 32'sd0, 32'sd0);
		send_word(REQ_POP, 32'sd0, 32'sd0);
		send_word(REQ_POP, -32'sd1, -32'sd1);
		// fill to the top with one shared priority, then overflow
		for (int k = 0; k < DEPTH - 3; k++)
			send_word(REQ_PUSH, 32'sd100 + k, 32'sd5);
		send_word(REQ_PUSH, 32'sh55aa55aa, 32'sh7fffffff);
		send_word(REQ_POP, 32'sd0, 32'sd0);

		// random: fill and drain runs, under three sender idle mixes
		push_odds = 50;
		run_left = 0;
		no_idle_left = 0;
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 0 : (phase == 1) ? 68 : 35;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (run_left == 0) begin
					run_left = $urandom_range(40, 8);
					case ($urandom_range(4))
						0, 1:    push_odds = 85;
						2, 3:    push_odds = 15;
						default: push_odds = 50;
					endcase
				end
				run_left--;
				// now and then a burst with no gaps even in an idling mix
				if (no_idle_left == 0 && $urandom_range(15) == 0)
					no_idle_left = $urandom_range(30, 5);
				if (no_idle_left > 0)
					no_idle_left--;
				else
					sender_gap(idle_pct);
				if ($urandom_range(99) < push_odds)
					send_word(REQ_PUSH, $urandom, pick_priority());
				else
					send_word(REQ_POP, $urandom, $urandom);
			end
		end
		start <= 1'b0;

		// drain: wait for every outstanding word, then catch stray words
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered %0d pushes (%0d dropped on full) and %0d pops (%0d on empty)",
			push_cnt, overflow_cnt, pop_cnt, underflow_cnt);
		$display("sender idle mixes of 0, 68 and 35 percent, %0d mismatches", fail_total);
		if (fail_total == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
